// ===== rtl/core/dva_pkg.sv =====
// dva_pkg: shared types and constants for the directed vector angle block.
// No dependencies.
package dva_pkg;

    localparam int COMPONENT_BITS  = 16;
    localparam int ANGLE_FRAC_BITS = 7;
    localparam int CORDIC_STEPS    = 30;
    localparam int ANGLE_BITS      = 16;
    localparam int PROD_BITS       = 2 * COMPONENT_BITS + 2;
    localparam int SQ_BITS         = 62;
    localparam int ROOT_BITS       = 31;
    localparam int CX_BITS         = 34;
    localparam int ZW              = 34;
    localparam int SCALE_HI        = 30;
    localparam int SCALE_LO        = 29;
    localparam logic [ANGLE_BITS-1:0] FULL_TURN = ANGLE_BITS'(360 << ANGLE_FRAC_BITS);

    typedef logic signed [COMPONENT_BITS-1:0] t_comp;
    typedef logic signed [PROD_BITS-1:0]      t_prod;

    typedef struct packed {
        t_comp first_x;
        t_comp first_y;
        t_comp first_z;
        t_comp second_x;
        t_comp second_y;
        t_comp second_z;
        t_comp normal_x;
        t_comp normal_y;
        t_comp normal_z;
    } t_in_beat;

    typedef struct packed {
        logic [ANGLE_BITS-1:0] angle_deg;
        logic                  degenerate;
    } t_out_beat;

    // Side information carried alongside each item through the pipe.
    typedef struct packed {
        logic degen;
        logic flip;
    } t_side;

    function automatic logic [ZW-1:0] atan_turn(input int i);
        logic [31:0] t;
        begin
            t = 32'd0;
            unique case (i)
                0:  t = 32'd536870912; 1:  t = 32'd316933406;
                2:  t = 32'd167458907; 3:  t = 32'd85004756;
                4:  t = 32'd42667331;  5:  t = 32'd21354465;
                6:  t = 32'd10679838;  7:  t = 32'd5340245;
                8:  t = 32'd2670163;   9:  t = 32'd1335087;
                10: t = 32'd667544;    11: t = 32'd333772;
                12: t = 32'd166886;    13: t = 32'd83443;
                14: t = 32'd41722;     15: t = 32'd20861;
                16: t = 32'd10430;     17: t = 32'd5215;
                18: t = 32'd2608;      19: t = 32'd1304;
                20: t = 32'd652;       21: t = 32'd326;
                22: t = 32'd163;       23: t = 32'd81;
                24: t = 32'd41;        25: t = 32'd20;
                26: t = 32'd10;        27: t = 32'd5;
                28: t = 32'd3;         29: t = 32'd1;
                default: t = 32'd0;
            endcase
            atan_turn = ZW'(t);
        end
    endfunction

endpackage

// ===== rtl/core/directed_vector_angle.sv =====
// directed_vector_angle: top level, handshake and pipeline control.
// Depends on dva_pkg, dva_front, dva_sqrt, dva_cordic.
//
// Takes one beat per cycle unless the pipe holds, and returns one result beat for
// each, in order. From input accept to output valid a beat passes six stages of
// products, sums and normalization, sixteen of square root (two root bits
// per stage), sixteen of CORDIC (two rotations per stage) and two of degree
// scaling. The whole pipe advances together; it holds only when the output
// register is full and not being taken, so a stall loses and repeats nothing.
module directed_vector_angle (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  dva_pkg::t_in_beat   i_data,
    output logic                o_valid,
    input  logic                i_ready,
    output dva_pkg::t_out_beat  o_data
);
    import dva_pkg::*;

    localparam int LAT = 40;

    logic en;
    logic [LAT-1:0] r_vld;

    // advance whenever the output slot is free or being drained
    assign en      = !r_vld[LAT-1] || i_ready;
    assign o_ready = en;
    assign o_valid = r_vld[LAT-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[LAT-2:0], i_valid};
        end
    end

    logic [CX_BITS-1:0] f_dm, s_dm;
    logic [SQ_BITS-1:0] f_sq;
    logic [ROOT_BITS-1:0] s_root;
    logic f_dneg, f_degen, f_dirpos, s_dneg;
    t_side f_side, s_side;

    dva_front u_front (
        .i_clk(i_clk), .i_en(en), .i_beat(i_data),
        .o_dm(f_dm), .o_dneg(f_dneg), .o_sq(f_sq),
        .o_degen(f_degen), .o_dirpos(f_dirpos)
    );

    assign f_side.degen = f_degen;
    assign f_side.flip  = f_dirpos;

    dva_sqrt u_sqrt (
        .i_clk(i_clk), .i_en(en), .i_sq(f_sq), .i_dm(f_dm),
        .i_dneg(f_dneg), .i_side(f_side),
        .o_root(s_root), .o_dm(s_dm), .o_dneg(s_dneg), .o_side(s_side)
    );

    dva_cordic u_cordic (
        .i_clk(i_clk), .i_en(en), .i_root(s_root), .i_dm(s_dm),
        .i_dneg(s_dneg), .i_side(s_side), .o_beat(o_data)
    );

endmodule

// ===== rtl/core/dva_front.sv =====
// dva_front: products, dot/cross sums, normalization and squaring.
// Depends on dva_pkg. Fixed latency, advances when i_en.
module dva_front (
    input  logic                    i_clk,
    input  logic                    i_en,
    input  dva_pkg::t_in_beat       i_beat,
    output logic [dva_pkg::CX_BITS-1:0] o_dm,
    output logic                    o_dneg,
    output logic [dva_pkg::SQ_BITS-1:0] o_sq,
    output logic                    o_degen,
    output logic                    o_dirpos
);
    import dva_pkg::*;

    localparam int DW = PROD_BITS + 2;   // sum of three products
    localparam int MW = 64;

    // stage 1: nine products plus direction-test inputs
    t_prod r_p [0:8];
    t_comp r_n [0:2];
    logic  r_degen1;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p[0] <= PROD_BITS'(i_beat.first_x * i_beat.second_x);
            r_p[1] <= PROD_BITS'(i_beat.first_y * i_beat.second_y);
            r_p[2] <= PROD_BITS'(i_beat.first_z * i_beat.second_z);
            r_p[3] <= PROD_BITS'(i_beat.first_y * i_beat.second_z);
            r_p[4] <= PROD_BITS'(i_beat.first_z * i_beat.second_y);
            r_p[5] <= PROD_BITS'(i_beat.first_z * i_beat.second_x);
            r_p[6] <= PROD_BITS'(i_beat.first_x * i_beat.second_z);
            r_p[7] <= PROD_BITS'(i_beat.first_x * i_beat.second_y);
            r_p[8] <= PROD_BITS'(i_beat.first_y * i_beat.second_x);
            r_n[0] <= i_beat.normal_x;
            r_n[1] <= i_beat.normal_y;
            r_n[2] <= i_beat.normal_z;
            r_degen1 <= ((i_beat.first_x == '0) && (i_beat.first_y == '0) &&
                         (i_beat.first_z == '0)) ||
                        ((i_beat.second_x == '0) && (i_beat.second_y == '0) &&
                         (i_beat.second_z == '0));
        end
    end

    // stage 2: dot and cross sums
    logic signed [DW-1:0] r_dot, r_c [0:2];
    t_comp r_n2 [0:2];
    logic  r_degen2;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_dot  <= DW'(r_p[0]) + DW'(r_p[1]) + DW'(r_p[2]);
            r_c[0] <= DW'(r_p[3]) - DW'(r_p[4]);
            r_c[1] <= DW'(r_p[5]) - DW'(r_p[6]);
            r_c[2] <= DW'(r_p[7]) - DW'(r_p[8]);
            r_n2     <= r_n;
            r_degen2 <= r_degen1;
        end
    end

    // stage 3: magnitudes, direction products, largest magnitude
    logic [DW-1:0] n_mag [0:3];
    logic [DW-1:0] n_max;
    localparam int TW = DW + COMPONENT_BITS;
    logic [DW-1:0] r_mag [0:3];
    logic [DW-1:0] r_max;
    logic signed [TW-1:0] r_t [0:2];
    logic r_dneg3, r_degen3;

    always_comb begin
        n_mag[0] = r_dot[DW-1] ? DW'(-r_dot) : DW'(r_dot);
        for (int k = 0; k < 3; k++) begin
            n_mag[k+1] = r_c[k][DW-1] ? DW'(-r_c[k]) : DW'(r_c[k]);
        end
        n_max = n_mag[0];
        for (int k = 1; k < 4; k++) begin
            if (n_mag[k] > n_max) n_max = n_mag[k];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_mag    <= n_mag;
            r_max    <= n_max;
            r_dneg3  <= r_dot[DW-1];
            r_degen3 <= r_degen2;
            for (int k = 0; k < 3; k++) begin
                r_t[k] <= TW'(r_c[k]) * TW'(r_n2[k]);
            end
        end
    end

    // stage 4: shift amount applied; direction sum
    logic [6:0] n_lz;
    logic [MW-1:0] n_sh [0:3];
    logic [CX_BITS-1:0] r_s [0:3];
    logic r_dneg4, r_degen4, r_dirpos4;
    logic signed [TW+1:0] n_tsum;

    always_comb begin
        n_lz = '0;
        for (int b = 0; b < DW; b++) begin
            if (r_max[b]) n_lz = 7'(b);
        end
        for (int k = 0; k < 4; k++) begin
            if (r_max == '0) begin
                n_sh[k] = MW'(r_mag[k]);
            end else if (n_lz >= 7'(SCALE_HI)) begin
                n_sh[k] = MW'(r_mag[k]) >> (n_lz - 7'(SCALE_LO));
            end else begin
                n_sh[k] = MW'(r_mag[k]) << (7'(SCALE_LO) - n_lz);
            end
        end
        n_tsum = (TW+2)'(r_t[0]) + (TW+2)'(r_t[1]) + (TW+2)'(r_t[2]);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < 4; k++) r_s[k] <= CX_BITS'(n_sh[k]);
            r_dneg4   <= r_dneg3;
            r_degen4  <= r_degen3;
            r_dirpos4 <= (n_tsum > 0);
        end
    end

    // stage 5: squares (each under 2^60)
    logic [SQ_BITS-1:0] r_q [0:2];
    logic [CX_BITS-1:0] r_dm5;
    logic r_dneg5, r_degen5, r_dirpos5;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < 3; k++) begin
                r_q[k] <= SQ_BITS'(r_s[k+1][29:0] * r_s[k+1][29:0]);
            end
            r_dm5     <= r_s[0];
            r_dneg5   <= r_dneg4;
            r_degen5  <= r_degen4;
            r_dirpos5 <= r_dirpos4;
        end
    end

    // stage 6: sum of squares
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_sq     <= r_q[0] + r_q[1] + r_q[2];
            o_dm     <= r_dm5;
            o_dneg   <= r_dneg5;
            o_degen  <= r_degen5;
            o_dirpos <= r_dirpos5;
        end
    end

endmodule

// ===== rtl/core/dva_sqrt.sv =====
// dva_sqrt: pipelined integer square root, two result bits per stage.
// Depends on dva_pkg. Carries the dot magnitude, its sign and side bits along.
module dva_sqrt (
    input  logic                        i_clk,
    input  logic                        i_en,
    input  logic [dva_pkg::SQ_BITS-1:0] i_sq,
    input  logic [dva_pkg::CX_BITS-1:0] i_dm,
    input  logic                        i_dneg,
    input  dva_pkg::t_side              i_side,
    output logic [dva_pkg::ROOT_BITS-1:0] o_root,
    output logic [dva_pkg::CX_BITS-1:0] o_dm,
    output logic                        o_dneg,
    output dva_pkg::t_side              o_side
);
    import dva_pkg::*;

    localparam int NST = (ROOT_BITS + 1) / 2;   // 16 stages
    localparam int RW  = SQ_BITS + 2;

    logic [RW-1:0]        r_rem  [0:NST];
    logic [ROOT_BITS-1:0] r_rt   [0:NST];
    logic [CX_BITS-1:0]   r_dm   [0:NST];
    logic                 r_dn   [0:NST];
    t_side                r_sd   [0:NST];

    always_comb begin
        r_rem[0] = RW'(i_sq);
        r_rt[0]  = '0;
        r_dm[0]  = i_dm;
        r_dn[0]  = i_dneg;
        r_sd[0]  = i_side;
    end

    // restoring root: bit pairs from the top, two per stage
    for (genvar s = 0; s < NST; s++) begin : g_st
        logic [RW-1:0] n_rem;
        logic [ROOT_BITS-1:0] n_rt;
        logic [RW-1:0] t;
        always_comb begin
            n_rem = r_rem[s];
            n_rt  = r_rt[s];
            for (int j = 0; j < 2; j++) begin
                if (2 * s + j < ROOT_BITS) begin
                    t = ((RW'(n_rt) << 2) | RW'(1)) << (2 * (ROOT_BITS - 1 - 2 * s - j));
                    n_rt = n_rt << 1;
                    if (n_rem >= t) begin
                        n_rem = n_rem - t;
                        n_rt  = n_rt | ROOT_BITS'(1);
                    end
                end
            end
        end
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[s+1] <= n_rem;
                r_rt[s+1]  <= n_rt;
                r_dm[s+1]  <= r_dm[s];
                r_dn[s+1]  <= r_dn[s];
                r_sd[s+1]  <= r_sd[s];
            end
        end
    end

    assign o_root = r_rt[NST];
    assign o_dm   = r_dm[NST];
    assign o_dneg = r_dn[NST];
    assign o_side = r_sd[NST];

endmodule

// ===== rtl/core/dva_cordic.sv =====
// dva_cordic: CORDIC vectoring, two rotations per stage, and degree scaling.
// Depends on dva_pkg.
module dva_cordic (
    input  logic                          i_clk,
    input  logic                          i_en,
    input  logic [dva_pkg::ROOT_BITS-1:0] i_root,
    input  logic [dva_pkg::CX_BITS-1:0]   i_dm,
    input  logic                          i_dneg,
    input  dva_pkg::t_side                i_side,
    output dva_pkg::t_out_beat            o_beat
);
    import dva_pkg::*;

    localparam int NST = CORDIC_STEPS / 2;
    localparam int W   = 34;

    logic signed [W-1:0]  r_x [0:NST];
    logic signed [W-1:0]  r_y [0:NST];
    logic signed [ZW-1:0] r_z [0:NST];
    t_side                r_sd [0:NST];

    // pre-rotation into the right half plane
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (i_dneg && i_dm != '0) begin
                r_x[0] <= W'(i_root);
                r_y[0] <= W'(i_dm);
                r_z[0] <= ZW'(64'd1 << 30);
            end else begin
                r_x[0] <= W'(i_dm);
                r_y[0] <= W'(i_root);
                r_z[0] <= '0;
            end
            r_sd[0] <= i_side;
        end
    end

    for (genvar s = 0; s < NST; s++) begin : g_rot
        logic signed [W-1:0]  n_x, n_y, dx, dy;
        logic signed [ZW-1:0] n_z;
        always_comb begin
            n_x = r_x[s];
            n_y = r_y[s];
            n_z = r_z[s];
            for (int j = 0; j < 2; j++) begin
                dx = n_y >>> (2 * s + j);
                dy = n_x >>> (2 * s + j);
                if (n_y > 0) begin
                    n_x = n_x + dx;
                    n_y = n_y - dy;
                    n_z = n_z + atan_turn(2 * s + j);
                end else begin
                    n_x = n_x - dx;
                    n_y = n_y + dy;
                    n_z = n_z - atan_turn(2 * s + j);
                end
            end
        end
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_x[s+1]  <= n_x;
                r_y[s+1]  <= n_y;
                r_z[s+1]  <= n_z;
                r_sd[s+1] <= r_sd[s];
            end
        end
    end

    // degree scaling: z * 360 * 2^F, rounded, over 2^32
    logic [31:0] n_zc;
    logic [63:0] r_prod;
    t_side       r_sdm;
    logic [63:0] n_deg;
    logic [ANGLE_BITS-1:0] n_out;

    always_comb begin
        n_zc = r_z[NST][ZW-1] ? 32'd0 : r_z[NST][31:0];
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_prod <= 64'(n_zc) * 64'(360 << ANGLE_FRAC_BITS);
            r_sdm  <= r_sd[NST];
        end
    end

    always_comb begin
        n_deg = (r_prod + (64'd1 << 31)) >> 32;
        n_out = ANGLE_BITS'(n_deg);
        if (r_sdm.flip && n_out != '0) n_out = FULL_TURN - n_out;
        if (r_sdm.degen) n_out = '0;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_beat.angle_deg  <= n_out;
            o_beat.degenerate <= r_sdm.degen;
        end
    end

endmodule

// ===== rtl/core/dva_checker.sv =====
// dva_checker: port-level checks on the directed vector angle block.
// Depends on dva_pkg; bound to directed_vector_angle.
module dva_port_checks (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               o_ready,
    input logic               o_valid,
    input logic               i_ready,
    input dva_pkg::t_out_beat o_data
);
    import dva_pkg::*;

    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_data.angle_deg < FULL_TURN) else $error("angle out of range");

    a_degen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_data.degenerate) |-> o_data.angle_deg == '0)
        else $error("degenerate with nonzero angle");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=> (o_valid && $stable(o_data)))
        else $error("output beat dropped under stall");

    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_valid) |-> o_ready) else $error("not ready with empty output");

endmodule

bind directed_vector_angle dva_port_checks u_dva_port_checks (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .o_ready(o_ready),
    .o_valid(o_valid), .i_ready(i_ready), .o_data(o_data)
);
